[src/cclc_pkg.sv]
`timescale 1ns / 1ps
// shared types and defaults for the cycle label canonical check
// no dependencies

package cclc_pkg;

    localparam int MAX_CYCLE_DEF  = 64;
    localparam int LABEL_BITS_DEF = 8;

    // comparison sequencer states
    typedef enum logic [1:0] {
        W_IDLE,
        W_DIR,
        W_SCAN,
        W_HOLD
    } t_walk_state;

    // top level to sequencer
    typedef struct packed {
        logic start;
        logic slot_free;
    } t_walk_ctl;

    // sequencer to top level
    typedef struct packed {
        logic idle;
        logic done;
        logic canon;
    } t_walk_sts;

endpackage

[src/cycle_label_canonical_check_top.sv]
`timescale 1ns / 1ps
// cycle label canonical check, top level; uses cclc_pkg, cclc_ram, cclc_walk
// loading: one transfer per cycle while the sequencer is idle; items up to the store depth
// are written to the node and edge stores; check: direction pass, then up to 2n readings of
// up to n steps each, backward then forward per start node (n = nodes); ready again in the
// cycle the result becomes valid, later while an earlier result waits
// synchronous active-low reset clears node count, sequencer state and output valid

module cycle_label_canonical_check_top
    import cclc_pkg::*;
#(
    parameter int MAX_CYCLE  = MAX_CYCLE_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LABEL_BITS-1:0] i_node_label,
    input  logic [LABEL_BITS-1:0] i_edge_label,
    input  logic                  i_last_node,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_is_canonical
);

    localparam int AW = $clog2(MAX_CYCLE);
    localparam int CW = $clog2(MAX_CYCLE + 1);

    // node count, saturating at the store depth
    logic [CW-1:0] r_count, n_count;
    logic          r_out_vld, n_out_vld;
    logic          r_out_canon, n_out_canon;

    logic          in_xfer;
    logic          store_we;
    logic [CW-1:0] cycle_n;

    t_walk_ctl     w_ctl;
    t_walk_sts     w_sts;

    logic [AW-1:0]         node_raddr_a, node_raddr_b;
    logic [AW-1:0]         edge_raddr_a, edge_raddr_b;
    logic [LABEL_BITS-1:0] node_a, node_b, edge_a, edge_b;

    // items are taken only while the sequencer is idle; a pending result
    // in the output register does not hold up loading of the next cycle
    assign o_ready  = w_sts.idle;
    assign in_xfer  = i_valid && o_ready;

    // entries beyond the store depth are dropped, count saturates
    assign store_we = in_xfer && (r_count < CW'(MAX_CYCLE));
    assign cycle_n  = store_we ? r_count + CW'(1) : r_count;

    // the check begins on the last item; the result may leave once the
    // output register is empty or being emptied
    assign w_ctl.start     = in_xfer && i_last_node;
    assign w_ctl.slot_free = !r_out_vld || i_ready;

    always_comb begin
        n_count = r_count;
        if (in_xfer) begin
            if (i_last_node) begin
                n_count = '0;
            end else if (store_we) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // output register: loaded by the sequencer, cleared by a transfer
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_canon = r_out_canon;
        if (w_sts.done) begin
            n_out_vld   = 1'b1;
            n_out_canon = w_sts.canon;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_canon <= n_out_canon;
    end

    assign o_valid        = r_out_vld;
    assign o_is_canonical = r_out_canon;

    // node label store
    cclc_ram #(
        .DEPTH (MAX_CYCLE),
        .WIDTH (LABEL_BITS)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_node_label),
        .i_raddr_a (node_raddr_a),
        .i_raddr_b (node_raddr_b),
        .o_rdata_a (node_a),
        .o_rdata_b (node_b)
    );

    // edge label store, entry j holds the edge leaving node j
    cclc_ram #(
        .DEPTH (MAX_CYCLE),
        .WIDTH (LABEL_BITS)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_we      (store_we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_edge_label),
        .i_raddr_a (edge_raddr_a),
        .i_raddr_b (edge_raddr_b),
        .o_rdata_a (edge_a),
        .o_rdata_b (edge_b)
    );

    // step sequencer: reads both stores at two addresses each cycle and
    // compares the pairs lexicographically
    cclc_walk #(
        .MAX_CYCLE  (MAX_CYCLE),
        .LABEL_BITS (LABEL_BITS)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_n            (cycle_n),
        .i_node_a       (node_a),
        .i_node_b       (node_b),
        .i_edge_a       (edge_a),
        .i_edge_b       (edge_b),
        .o_node_raddr_a (node_raddr_a),
        .o_node_raddr_b (node_raddr_b),
        .o_edge_raddr_a (edge_raddr_a),
        .o_edge_raddr_b (edge_raddr_b),
        .o_sts          (w_sts)
    );

    // node count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CYCLE))
        else $error("node count beyond store depth");

    // a last item stops loading until its check has finished
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_last_node) |=> !o_ready)
        else $error("input taken while check in progress");

    // a finished check always lands in the output register
    a_done_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |=> (o_valid && (o_is_canonical == $past(w_sts.canon))))
        else $error("check result lost");

    // the count is cleared once a check is under way
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_sts.idle) |-> (r_count == '0))
        else $error("node count not cleared during check");

endmodule

[src/cclc_ram.sv]
`timescale 1ns / 1ps
// label store: one write port, two read ports with registered read data
// depends on nothing

module cclc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[src/cclc_walk.sv]
`timescale 1ns / 1ps
// comparison sequencer: direction pass, then forward and backward readings
// depends on cclc_pkg; drives the read ports of both label stores

module cclc_walk
    import cclc_pkg::*;
#(
    parameter int MAX_CYCLE  = MAX_CYCLE_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF,
    localparam int AW        = $clog2(MAX_CYCLE),
    localparam int CW        = $clog2(MAX_CYCLE + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_walk_ctl             i_ctl,
    input  logic [CW-1:0]         i_n,
    input  logic [LABEL_BITS-1:0] i_node_a,
    input  logic [LABEL_BITS-1:0] i_node_b,
    input  logic [LABEL_BITS-1:0] i_edge_a,
    input  logic [LABEL_BITS-1:0] i_edge_b,
    output logic [AW-1:0]         o_node_raddr_a,
    output logic [AW-1:0]         o_node_raddr_b,
    output logic [AW-1:0]         o_edge_raddr_a,
    output logic [AW-1:0]         o_edge_raddr_b,
    output t_walk_sts             o_sts
);

    t_walk_state r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_b, n_b;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_i, n_i;
    logic          r_fwd, n_fwd;
    logic          r_rev, n_rev;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_last, n_rd_last;
    logic          r_res, n_res;

    logic [AW-1:0] nm1;
    logic [CW-1:0] in_nm1;
    logic [AW-1:0] start_pos;
    logic          a_dec_mode;
    logic          b_dec_mode;
    logic          node_eq, lt, gt, eq;
    logic          issue;
    logic          read_end;

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] x,
                                            input logic [AW-1:0] top);
        return (x == '0) ? top : x - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] x,
                                            input logic [AW-1:0] top);
        return (x == top) ? '0 : x + AW'(1);
    endfunction

    assign nm1       = AW'(r_n - CW'(1));
    assign in_nm1    = i_n - CW'(1);
    assign start_pos = r_rev ? nm1 : '0;

    // lexicographic compare of one step: node pair first, then edge pair
    assign node_eq = (i_node_a == i_node_b);
    assign lt      = (i_node_a < i_node_b) || (node_eq && (i_edge_a < i_edge_b));
    assign gt      = (i_node_a > i_node_b) || (node_eq && (i_edge_a > i_edge_b));
    assign eq      = !lt && !gt;
    assign read_end = gt || (eq && r_rd_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            W_IDLE: begin
                if (i_ctl.start) begin
                    n_state = W_DIR;
                end
            end
            W_DIR: begin
                if (r_rd_vld && (!eq || r_rd_last)) begin
                    n_state = W_SCAN;
                end
            end
            W_SCAN: begin
                if (r_rd_vld && (lt || (read_end && r_fwd && (r_i == nm1)))) begin
                    n_state = W_HOLD;
                end
            end
            W_HOLD: begin
                if (i_ctl.slot_free) begin
                    n_state = W_IDLE;
                end
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    // outputs: read issue, addresses, status
    always_comb begin
        a_dec_mode = (r_state == W_DIR) || !r_fwd;
        b_dec_mode = (r_state == W_SCAN) && r_rev;
        issue      = ((r_state == W_DIR) || (r_state == W_SCAN))
                     && (!r_rd_vld || (eq && !r_rd_last));

        o_node_raddr_a = r_a;
        o_node_raddr_b = r_b;
        o_edge_raddr_a = a_dec_mode ? f_dec(r_a, nm1) : r_a;
        o_edge_raddr_b = b_dec_mode ? f_dec(r_b, nm1) : r_b;

        o_sts.idle  = (r_state == W_IDLE);
        o_sts.done  = (r_state == W_HOLD) && i_ctl.slot_free;
        o_sts.canon = r_res;
    end

    // datapath next values
    always_comb begin
        n_n       = r_n;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_fwd     = r_fwd;
        n_rev     = r_rev;
        n_res     = r_res;
        n_rd_vld  = issue;
        n_rd_last = r_rd_last;

        if (issue) begin
            n_rd_last = (r_cnt == nm1);
            n_cnt     = r_cnt + AW'(1);
            n_a       = a_dec_mode ? f_dec(r_a, nm1) : f_inc(r_a, nm1);
            n_b       = b_dec_mode ? f_dec(r_b, nm1) : f_inc(r_b, nm1);
        end

        case (r_state)
            W_IDLE: begin
                if (i_ctl.start) begin
                    n_n   = i_n;
                    n_a   = in_nm1[AW-1:0];
                    n_b   = '0;
                    n_cnt = '0;
                end
            end
            W_DIR: begin
                // first difference fixes the reference direction
                if (r_rd_vld && (!eq || r_rd_last)) begin
                    n_rev = lt;
                    n_i   = '0;
                    n_fwd = 1'b0;
                    n_a   = '0;
                    n_b   = lt ? nm1 : '0;
                    n_cnt = '0;
                end
            end
            W_SCAN: begin
                if (r_rd_vld) begin
                    if (lt) begin
                        n_res = 1'b0;
                    end else if (read_end) begin
                        if (!r_fwd) begin
                            n_fwd = 1'b1;
                            n_a   = r_i;
                            n_b   = start_pos;
                            n_cnt = '0;
                        end else if (r_i == nm1) begin
                            n_res = 1'b1;
                        end else begin
                            n_i   = r_i + AW'(1);
                            n_fwd = 1'b0;
                            n_a   = r_i + AW'(1);
                            n_b   = start_pos;
                            n_cnt = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= W_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_a       <= n_a;
        r_b       <= n_b;
        r_cnt     <= n_cnt;
        r_i       <= n_i;
        r_fwd     <= n_fwd;
        r_rev     <= n_rev;
        r_res     <= n_res;
        r_rd_last <= n_rd_last;
    end

endmodule
